// ===== design/fpdc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpdc_pkg
// Shared types and constants of the flight phase deploy controller.
// ----------------------------------------------------------------------------
package fpdc_pkg;

  localparam int unsigned ValW   = 24;  // Q16.8 signed sensor values
  localparam int unsigned AltCfgW = 23; // launch altitude, unsigned
  localparam int unsigned CntW   = 4;   // confirmation counters
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CntW-1:0] CntMax = 4'd15;

  // Register reset values
  localparam logic [AltCfgW-1:0] LaunchAltRst  = 23'd51200;  // 200 m
  localparam logic [ValW-1:0]    LaunchAccRst  = '0;
  localparam logic [ValW-1:0]    MainVelRst    = '0;
  localparam logic [ValW-1:0]    BackupVelRst  = '0;
  localparam logic [CntW-1:0]    ConfirmRst    = 4'd5;

  typedef enum logic [1:0] {
    MODE_GROUND  = 2'd0,
    MODE_FLIGHT  = 2'd1,
    MODE_DESCENT = 2'd2,
    MODE_DONE    = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LAUNCH_ALT  = 3'd0,
    REG_LAUNCH_ACC  = 3'd1,
    REG_MAIN_VEL    = 3'd2,
    REG_BACKUP_VEL  = 3'd3,
    REG_CONFIRM     = 3'd4
  } reg_idx_e;

  // Result of one confirmation phase evaluation
  typedef struct packed {
    logic            fire;
    logic [CntW-1:0] baro_cnt;
    logic [CntW-1:0] inert_cnt;
  } phase_res_t;

endpackage

// ===== design/flight_phase_deploy_controller_core.sv =====
// ----------------------------------------------------------------------------
// flight_phase_deploy_controller_core
// Flight mode tracker and deploy trigger: one result per sensor snapshot.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Payload
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tdata: altitude, accel_z, baro_velocity,
//           |           |        inertial_velocity; tuser: tipped_over
//  m_axis   | out       | tdata: mode, fire_main, fire_backup
//  cfg      | in        | cfg_index_i selects register, cfg_data_i value
//
//  One item per cycle while m_axis takes results: the snapshot is evaluated
//  against the mode and counter registers in the accept cycle and the result
//  lands in the output register at that edge. The mode/counter loop is the
//  only feedback path. s_axis_tready is high whenever the output register is
//  empty or being drained, so a stall on m_axis holds the result and
//  back-pressures the input. Reset enters ground mode with all counters
//  cleared and registers at their defaults. cfg_ready_o is always high.
//
module flight_phase_deploy_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [23:0] altitude, [47:24] accel_z, [71:48] baro_velocity,
  // [95:72] inertial_velocity
  input  logic [95:0] s_axis_tdata,
  // [0] tipped_over
  input  logic [0:0]  s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] mode, [2] fire_main, [3] fire_backup, [7:4] zero
  output logic [7:0]  m_axis_tdata,

  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fpdc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [fpdc_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned VW = fpdc_pkg::ValW;
  localparam int unsigned CW = fpdc_pkg::CntW;

  // ---------------------------------------------------------------- config
  logic [fpdc_pkg::AltCfgW-1:0] launch_alt_q;
  logic signed [VW-1:0]         launch_acc_q, main_vel_q, backup_vel_q;
  logic [CW-1:0]                confirm_q;
  logic                         cfg_xfer;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_alt_q <= fpdc_pkg::LaunchAltRst;
      launch_acc_q <= fpdc_pkg::LaunchAccRst;
      main_vel_q   <= fpdc_pkg::MainVelRst;
      backup_vel_q <= fpdc_pkg::BackupVelRst;
      confirm_q    <= fpdc_pkg::ConfirmRst;
    end else if (cfg_xfer) begin
      unique case (cfg_index_i)
        fpdc_pkg::REG_LAUNCH_ALT: launch_alt_q <= cfg_data_i[fpdc_pkg::AltCfgW-1:0];
        fpdc_pkg::REG_LAUNCH_ACC: launch_acc_q <= cfg_data_i[VW-1:0];
        fpdc_pkg::REG_MAIN_VEL:   main_vel_q   <= cfg_data_i[VW-1:0];
        fpdc_pkg::REG_BACKUP_VEL: backup_vel_q <= cfg_data_i[VW-1:0];
        fpdc_pkg::REG_CONFIRM:    confirm_q    <= cfg_data_i[CW-1:0];
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- input
  logic signed [VW-1:0] alt, acc, baro, inert;
  logic                 tipped;
  logic                 in_xfer;

  assign alt    = s_axis_tdata[23:0];
  assign acc    = s_axis_tdata[47:24];
  assign baro   = s_axis_tdata[71:48];
  assign inert  = s_axis_tdata[95:72];
  assign tipped = s_axis_tuser[0];

  logic out_valid_q;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- state
  fpdc_pkg::mode_e mode_q, mode_d;
  logic [CW-1:0]   baro_main_cnt_q, inert_main_cnt_q;
  logic [CW-1:0]   baro_backup_cnt_q, inert_backup_cnt_q;
  logic            fire_main_d, fire_backup_d;
  logic            fire_main_q, fire_backup_q;

  fpdc_pkg::phase_res_t main_res, backup_res;

  fpdc_phase u_main_phase (
    .baro_i      (baro),
    .inert_i     (inert),
    .limit_i     (main_vel_q),
    .tipped_i    (tipped),
    .confirm_i   (confirm_q),
    .baro_cnt_i  (baro_main_cnt_q),
    .inert_cnt_i (inert_main_cnt_q),
    .res_o       (main_res)
  );

  fpdc_phase u_backup_phase (
    .baro_i      (baro),
    .inert_i     (inert),
    .limit_i     (backup_vel_q),
    .tipped_i    (tipped),
    .confirm_i   (confirm_q),
    .baro_cnt_i  (baro_backup_cnt_q),
    .inert_cnt_i (inert_backup_cnt_q),
    .res_o       (backup_res)
  );

  // launch detect: altitude is signed, the threshold unsigned 23 bit
  logic launch;
  assign launch = ($signed({alt[VW-1], alt}) > $signed({2'b00, launch_alt_q})) ||
                  (acc > launch_acc_q);

  always_comb begin
    mode_d        = mode_q;
    fire_main_d   = 1'b0;
    fire_backup_d = 1'b0;
    unique case (mode_q)
      fpdc_pkg::MODE_GROUND: begin
        if (launch) mode_d = fpdc_pkg::MODE_FLIGHT;
      end
      fpdc_pkg::MODE_FLIGHT: begin
        if (main_res.fire) begin
          fire_main_d = 1'b1;
          mode_d      = fpdc_pkg::MODE_DESCENT;
        end
      end
      fpdc_pkg::MODE_DESCENT: begin
        if (backup_res.fire) begin
          fire_backup_d = 1'b1;
          mode_d        = fpdc_pkg::MODE_DONE;
        end
      end
      default: ;  // done: snapshot ignored
    endcase
  end

  // counters only move in their own phase; a fire leaves them untouched
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q             <= fpdc_pkg::MODE_GROUND;
      baro_main_cnt_q    <= '0;
      inert_main_cnt_q   <= '0;
      baro_backup_cnt_q  <= '0;
      inert_backup_cnt_q <= '0;
    end else if (in_xfer) begin
      mode_q <= mode_d;
      if (mode_q == fpdc_pkg::MODE_FLIGHT) begin
        baro_main_cnt_q  <= main_res.baro_cnt;
        inert_main_cnt_q <= main_res.inert_cnt;
      end
      if (mode_q == fpdc_pkg::MODE_DESCENT) begin
        baro_backup_cnt_q  <= backup_res.baro_cnt;
        inert_backup_cnt_q <= backup_res.inert_cnt;
      end
    end
  end

  // ---------------------------------------------------------------- output
  fpdc_pkg::mode_e res_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_mode_q    <= mode_d;
      fire_main_q   <= fire_main_d;
      fire_backup_q <= fire_backup_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, fire_backup_q, fire_main_q, res_mode_q};

  // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
  // a result never fires both deploys
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(fire_main_q && fire_backup_q))
    else $error("both deploy pulses in one result");

  // a main fire always reports descent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && fire_main_q) |-> (res_mode_q == fpdc_pkg::MODE_DESCENT))
    else $error("main fire without descent mode");

  // done is terminal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == fpdc_pkg::MODE_DONE) |=> (mode_q == fpdc_pkg::MODE_DONE))
    else $error("left done mode");

  // the baro main and inertial backup confirmation counters never decrease
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (baro_main_cnt_q >= $past(baro_main_cnt_q)) &&
             (inert_backup_cnt_q >= $past(inert_backup_cnt_q)))
    else $error("confirmation counter decreased");
`endif

endmodule

// ===== design/fpdc_phase.sv =====
// ----------------------------------------------------------------------------
// fpdc_phase
// One confirmation phase: compares both velocities against a limit, applies
// the tip-over priority rules and returns the fire flag and next counters.
// ----------------------------------------------------------------------------
module fpdc_phase (
  input  logic signed [fpdc_pkg::ValW-1:0] baro_i,
  input  logic signed [fpdc_pkg::ValW-1:0] inert_i,
  input  logic signed [fpdc_pkg::ValW-1:0] limit_i,
  input  logic                             tipped_i,
  input  logic [fpdc_pkg::CntW-1:0]        confirm_i,
  input  logic [fpdc_pkg::CntW-1:0]        baro_cnt_i,
  input  logic [fpdc_pkg::CntW-1:0]        inert_cnt_i,
  output fpdc_pkg::phase_res_t             res_o
);

  logic b, i, b_ok, i_ok;
  logic inc_b, inc_i;
  logic fire;

  assign b    = baro_i <= limit_i;
  assign i    = inert_i <= limit_i;
  assign b_ok = b && (baro_cnt_i >= confirm_i);
  assign i_ok = i && (inert_cnt_i >= confirm_i);

  always_comb begin
    if (tipped_i) begin
      // baro reading has priority; inertial only looked at when baro is high
      fire  = b_ok || (!b && i_ok);
      inc_b = b && !b_ok;
      inc_i = !b && i && !i_ok;
    end else begin
      // both sensors must confirm
      fire  = b_ok && i_ok;
      inc_b = b && !b_ok;
      inc_i = b_ok && i && !i_ok;
    end
  end

  assign res_o.fire = fire;

  // saturating bumps
  assign res_o.baro_cnt  = (inc_b && baro_cnt_i != fpdc_pkg::CntMax) ?
                           baro_cnt_i + 1'b1 : baro_cnt_i;
  assign res_o.inert_cnt = (inc_i && inert_cnt_i != fpdc_pkg::CntMax) ?
                           inert_cnt_i + 1'b1 : inert_cnt_i;

endmodule

// ===== verif/flight_phase_deploy_controller_core_tb.sv =====
// ----------------------------------------------------------------------------
// flight_phase_deploy_controller_core_tb
// Self-checking bench for the flight phase deploy controller core.
// Sensor snapshots are streamed in with random gaps and the results are drained
// with random stalls. Every accepted snapshot is run through a local model of
// the mode machine and confirmation counters, and each result transfer is
// checked against the oldest prediction. Register writes happen only while
// the core is drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module flight_phase_deploy_controller_core_tb;

  localparam int unsigned ValW     = fpdc_pkg::ValW;
  localparam int unsigned AltCfgW  = fpdc_pkg::AltCfgW;
  localparam int unsigned CntW     = fpdc_pkg::CntW;
  localparam int unsigned CfgIdxW  = fpdc_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = fpdc_pkg::CfgDataW;

  localparam int ValMaxI = 8388607;   // largest Q16.8 value
  localparam int ValMinI = -8388608;  // smallest Q16.8 value

  // Limits held by the model, mirrored from the register writes
  typedef struct {
    logic [AltCfgW-1:0]     alt_thr;
    logic signed [ValW-1:0] acc_thr;
    logic signed [ValW-1:0] main_lim;
    logic signed [ValW-1:0] bk_lim;
    logic [CntW-1:0]        confirm;
  } limits_t;

  // Mode and the four confirmation counters
  typedef struct {
    fpdc_pkg::mode_e mode;
    logic [CntW-1:0] baro_main;
    logic [CntW-1:0] inert_main;
    logic [CntW-1:0] baro_bk;
    logic [CntW-1:0] inert_bk;
  } flight_state_t;

  // One sensor snapshot
  typedef struct {
    logic signed [ValW-1:0] alt;
    logic signed [ValW-1:0] acc;
    logic signed [ValW-1:0] bvel;
    logic signed [ValW-1:0] ivel;
    logic                   tipped;
  } snapshot_t;

  // One result transfer
  typedef struct {
    fpdc_pkg::mode_e mode;
    logic            fire_main;
    logic            fire_backup;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [23:0] altitude, [47:24] accel_z, [71:48] baro_velocity,
  // [95:72] inertial_velocity
  logic [95:0] s_axis_tdata;
  // [0] tipped_over
  logic [0:0]  s_axis_tuser;

  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [1:0] mode, [2] fire_main, [3] fire_backup, [7:4] zero
  logic [7:0]  m_axis_tdata;

  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  limits_t       lims;       // register contents as the core should see them
  flight_state_t flight_st;  // model state, advanced on input transfers
  flight_state_t plan_st;    // look-ahead copy used while building stimulus

  snapshot_t plan_q[$];      // snapshots waiting to be sent
  verdict_t  verdict_q[$];   // predicted results not yet seen

  int fail_count = 0;
  logic in_taken = 1'b0;     // input transfer happened at the last rising edge
  int in_gap = 0;
  int in_burst = 0;
  int out_stall = 0;
  int out_burst = 0;

  flight_phase_deploy_controller_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #4ms;
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  // Counters stick at full scale
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
    return (c == fpdc_pkg::CntMax) ? c : c + 1'b1;
  endfunction

  // One confirmation phase. Baro has priority; the tipped and upright cases
  // differ in whether inertial readings alone may count and fire.
  function automatic logic confirm_phase(input logic signed [ValW-1:0] lim,
                                         input logic tipped,
                                         input logic signed [ValW-1:0] bv,
                                         input logic signed [ValW-1:0] iv,
                                         input logic [CntW-1:0] need,
                                         inout logic [CntW-1:0] cb,
                                         inout logic [CntW-1:0] ci);
    logic b, i, b_ok, i_ok;
    b    = bv <= lim;
    i    = iv <= lim;
    b_ok = b && (cb >= need);
    i_ok = i && (ci >= need);
    confirm_phase = 1'b0;
    if (tipped) begin
      if (b_ok) confirm_phase = 1'b1;
      else if (b) cb = sat_inc(cb);
      else if (i_ok) confirm_phase = 1'b1;
      else if (i) ci = sat_inc(ci);
    end else if (b_ok) begin
      // baro confirmed, inertial has to agree before firing
      if (i_ok) confirm_phase = 1'b1;
      else if (i) ci = sat_inc(ci);
    end else if (b) begin
      cb = sat_inc(cb);
    end
  endfunction

  function automatic verdict_t advance_mode(input limits_t c, inout flight_state_t st,
                                            input snapshot_t s);
    verdict_t r;
    r.fire_main   = 1'b0;
    r.fire_backup = 1'b0;
    case (st.mode)
      fpdc_pkg::MODE_GROUND: begin
        if (s.alt > $signed({1'b0, c.alt_thr}) || s.acc > c.acc_thr)
          st.mode = fpdc_pkg::MODE_FLIGHT;
      end
      fpdc_pkg::MODE_FLIGHT: begin
        if (confirm_phase(c.main_lim, s.tipped, s.bvel, s.ivel, c.confirm,
                          st.baro_main, st.inert_main)) begin
          r.fire_main = 1'b1;
          st.mode     = fpdc_pkg::MODE_DESCENT;
        end
      end
      fpdc_pkg::MODE_DESCENT: begin
        if (confirm_phase(c.bk_lim, s.tipped, s.bvel, s.ivel, c.confirm,
                          st.baro_bk, st.inert_bk)) begin
          r.fire_backup = 1'b1;
          st.mode       = fpdc_pkg::MODE_DONE;
        end
      end
      default: ;  // done: input ignored
    endcase
    r.mode = st.mode;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic snapshot_t snap(input int a, input int c, input int bv, input int iv,
                                     input bit t);
    snapshot_t s;
    s.alt    = ValW'(a);
    s.acc    = ValW'(c);
    s.bvel   = ValW'(bv);
    s.ivel   = ValW'(iv);
    s.tipped = t;
    return s;
  endfunction

  // Value at or below a limit, or just/far above it. Mixes tiny offsets (hits
  // the compare boundary) with large ones (toggles high bits). Clipped to range.
  function automatic logic signed [ValW-1:0] around_limit(input logic signed [ValW-1:0] ref_v,
                                                          input bit at_or_below);
    int v;
    int span;
    span = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 4))
                                       : int'($urandom & 32'h7F_FFFF);
    v = ref_v;
    v = at_or_below ? v - span : v + 1 + span;
    if (v > ValMaxI) v = ValMaxI;
    if (v < ValMinI) v = ValMinI;
    return v[ValW-1:0];
  endfunction

  // Random snapshot shaped for the mode the core will be in when it arrives.
  // Unless leaving is allowed, a snapshot that would change mode is patched
  // into a harmless one so the run stays long in each mode.
  function automatic snapshot_t plan_snapshot(input bit may_leave);
    snapshot_t              s;
    flight_state_t          trial;
    verdict_t               unused;
    logic signed [ValW-1:0] lim;
    int                     p;
    s.alt    = ValW'($urandom);
    s.acc    = ValW'($urandom);
    s.bvel   = ValW'($urandom);
    s.ivel   = ValW'($urandom);
    s.tipped = 1'($urandom);
    lim = (plan_st.mode == fpdc_pkg::MODE_DESCENT) ? lims.bk_lim : lims.main_lim;
    p   = may_leave ? 60 : 35;
    case (plan_st.mode)
      fpdc_pkg::MODE_GROUND: begin
        if ($urandom_range(0, 5) != 0) begin
          s.alt = around_limit($signed({1'b0, lims.alt_thr}),
                               !(may_leave && $urandom_range(0, 4) == 0));
          s.acc = around_limit(lims.acc_thr, !(may_leave && $urandom_range(0, 4) == 0));
        end
      end
      fpdc_pkg::MODE_FLIGHT, fpdc_pkg::MODE_DESCENT: begin
        if ($urandom_range(0, 7) != 0) s.bvel = around_limit(lim, $urandom_range(0, 99) < p);
        if ($urandom_range(0, 7) != 0) s.ivel = around_limit(lim, $urandom_range(0, 99) < p);
      end
      default: ;
    endcase
    trial  = plan_st;
    unused = advance_mode(lims, trial, s);
    if (!may_leave && trial.mode != plan_st.mode) begin
      if (plan_st.mode == fpdc_pkg::MODE_GROUND) begin
        // equal to both thresholds: never a launch
        s.alt = $signed({1'b0, lims.alt_thr});
        s.acc = lims.acc_thr;
      end else begin
        // upright with baro above the limit changes nothing; not possible
        // when the limit is full scale, then the deploy simply goes ahead
        s.tipped = 1'b0;
        s.bvel   = around_limit(lim, 1'b0);
      end
    end
    return s;
  endfunction

  function automatic void enqueue_snapshot(input snapshot_t s);
    verdict_t unused;
    unused = advance_mode(lims, plan_st, s);
    plan_q.push_back(s);
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one, and every so
  // often a burst with no gaps at all.
  function automatic int draw_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst = $urandom_range(30, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CfgDataW-1:0] pick_cfg(input fpdc_pkg::reg_idx_e idx);
    logic [CfgDataW-1:0] d;
    int                  r;
    d = CfgDataW'($urandom);  // unused upper bits stay random
    r = $urandom_range(0, 9);
    case (idx)
      fpdc_pkg::REG_LAUNCH_ALT: begin
        if (r < 2) d[AltCfgW-1:0] = '1;
        else if (r < 4) d[AltCfgW-1:0] = '0;
        else if (r < 7) d[AltCfgW-1:0] = AltCfgW'($urandom_range(0, 60000));
      end
      fpdc_pkg::REG_CONFIRM: begin
        if (r < 3) d[CntW-1:0] = '0;
        else if (r < 6) d[CntW-1:0] = '1;
        else d[CntW-1:0] = CntW'($urandom_range(1, 14));
      end
      default: begin  // signed thresholds and velocity limits
        // a full-scale velocity limit counts every reading and forces the
        // deploy, so those stop one below it to keep the flight long
        if (r == 0) d = CfgDataW'(ValMinI);
        else if (r == 1) d = (idx == fpdc_pkg::REG_LAUNCH_ACC) ? CfgDataW'(ValMaxI)
                                                               : CfgDataW'(ValMaxI - 1);
        else if (r < 6) d = CfgDataW'(int'($urandom_range(0, 2000)) - 1000);
      end
    endcase
    return d;
  endfunction

  task automatic flag(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  // Leaves cfg_valid_i high so back-to-back writes need no drop in between;
  // the caller lowers it after the last one.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      fpdc_pkg::REG_LAUNCH_ALT: lims.alt_thr  = data[AltCfgW-1:0];
      fpdc_pkg::REG_LAUNCH_ACC: lims.acc_thr  = data[ValW-1:0];
      fpdc_pkg::REG_MAIN_VEL:   lims.main_lim = data[ValW-1:0];
      fpdc_pkg::REG_BACKUP_VEL: lims.bk_lim   = data[ValW-1:0];
      fpdc_pkg::REG_CONFIRM:    lims.confirm  = data[CntW-1:0];
      default: ;  // no such register, write dropped
    endcase
  endtask

  task automatic shuffle_regs();
    bit wrote;
    wrote = 1'b0;
    for (int k = fpdc_pkg::REG_LAUNCH_ALT; k <= fpdc_pkg::REG_CONFIRM; k++) begin
      if ($urandom_range(0, 1) == 1) begin
        write_reg(CfgIdxW'(k), pick_cfg(fpdc_pkg::reg_idx_e'(k)));
        wrote = 1'b1;
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      write_reg(CfgIdxW'(int'(fpdc_pkg::REG_CONFIRM) + 1 + int'($urandom_range(0, 2))),
                CfgDataW'($urandom));
      wrote = 1'b1;
    end
    if (wrote) @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  // Checked at rising edges, where everything from the falling edge is settled
  task automatic wait_drained();
    while (plan_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: next snapshot goes out at the falling edge after a transfer
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : feed_snapshots
    snapshot_t nxt;
    if (!s_axis_tvalid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (plan_q.size() != 0) begin
        nxt = plan_q.pop_front();
        s_axis_tdata  <= {nxt.ivel, nxt.bvel, nxt.acc, nxt.alt};
        s_axis_tuser  <= nxt.tipped;
        s_axis_tvalid <= 1'b1;
        in_gap = draw_gap(in_burst);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk_i) begin
    if (out_stall > 0) begin
      out_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      out_stall = draw_gap(out_burst);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on input transfers, check on result transfers
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_transfers
    snapshot_t s;
    verdict_t  want;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      s.alt    = s_axis_tdata[23:0];
      s.acc    = s_axis_tdata[47:24];
      s.bvel   = s_axis_tdata[71:48];
      s.ivel   = s_axis_tdata[95:72];
      s.tipped = s_axis_tuser[0];
      verdict_q.push_back(advance_mode(lims, flight_st, s));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        flag($sformatf("result 0x%02h with nothing pending", m_axis_tdata));
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata[1:0] !== want.mode)
          flag($sformatf("mode %0d, want %0d", m_axis_tdata[1:0], want.mode));
        if (m_axis_tdata[2] !== want.fire_main)
          flag($sformatf("fire_main %b, want %b", m_axis_tdata[2], want.fire_main));
        if (m_axis_tdata[3] !== want.fire_backup)
          flag($sformatf("fire_backup %b, want %b", m_axis_tdata[3], want.fire_backup));
        if (m_axis_tdata[7:4] !== 4'h0)
          flag($sformatf("pad bits 0x%01h, want zero", m_axis_tdata[7:4]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : run_flight
    // snapshots before the mode may move on: ground, flight, descent
    int exit_mark [4];
    int made;
    int tail;
    int phase_no;
    int n;

    exit_mark = '{320, 780, 1200, 0};
    made     = 0;
    tail     = 0;
    phase_no = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;

    lims.alt_thr  = fpdc_pkg::LaunchAltRst;
    lims.acc_thr  = fpdc_pkg::LaunchAccRst;
    lims.main_lim = fpdc_pkg::MainVelRst;
    lims.bk_lim   = fpdc_pkg::BackupVelRst;
    lims.confirm  = fpdc_pkg::ConfirmRst;
    flight_st = '{fpdc_pkg::MODE_GROUND, '0, '0, '0, '0};
    plan_st   = flight_st;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset thresholds: exactly at both limits is not a launch
    enqueue_snapshot(snap(51200, 0, 0, 0, 1'b0));
    enqueue_snapshot(snap(ValMinI, ValMinI, ValMinI, ValMinI, 1'b1));
    enqueue_snapshot(snap(-1, -1, ValMaxI, ValMaxI, 1'b0));
    enqueue_snapshot(snap(51200, 0, ValMaxI, ValMinI, 1'b1));
    wait_drained();

    // Unreachable launch thresholds; the bad-index write carries a zero that
    // would make almost anything launch if it landed in a real register
    write_reg(fpdc_pkg::REG_LAUNCH_ALT, '1);
    write_reg(fpdc_pkg::REG_LAUNCH_ACC, CfgDataW'(ValMaxI));
    write_reg(fpdc_pkg::REG_MAIN_VEL, CfgDataW'(ValMinI));
    write_reg(fpdc_pkg::REG_BACKUP_VEL, CfgDataW'(ValMaxI));
    write_reg(fpdc_pkg::REG_CONFIRM, '1);
    write_reg(CfgIdxW'(int'(fpdc_pkg::REG_CONFIRM) + 1), '0);
    @(negedge clk_i) cfg_valid_i <= 1'b0;

    // Field extremes and alternating bit patterns, all held in ground
    enqueue_snapshot(snap(ValMaxI, ValMaxI, ValMinI, ValMaxI, 1'b1));
    enqueue_snapshot(snap(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b0));
    enqueue_snapshot(snap(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 1'b1));
    enqueue_snapshot(snap(0, 0, 0, 0, 1'b0));
    enqueue_snapshot(snap(-1, -1, -1, -1, 1'b1));
    enqueue_snapshot(snap(ValMinI, ValMaxI, 0, -1, 1'b0));
    wait_drained();

    // Random phases: new register settings while drained, then a batch of
    // snapshots. Mode changes are held back until enough snapshots were spent
    // in the current mode; a short run in done mode closes the flight.
    while ((plan_st.mode != fpdc_pkg::MODE_DONE || tail < 30) && phase_no < 400) begin
      shuffle_regs();
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(10, 50);
      repeat (n) begin
        if (plan_st.mode == fpdc_pkg::MODE_DONE) tail++;
        else made++;
        enqueue_snapshot(plan_snapshot(made >= exit_mark[plan_st.mode]));
      end
      wait_drained();
      phase_no++;
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/fpdc_pkg.sv
design/fpdc_phase.sv
design/flight_phase_deploy_controller_core.sv
verif/flight_phase_deploy_controller_core_tb.sv
